// File: rtl/core/wrc_pkg.sv
// shared types and constants of the word run counter
`timescale 1ns / 1ps

package wrc_pkg;

  // fixed field widths of the stream words
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 16;

  // newline ends a word
  localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;

  // largest count shown on the output, in a 32-bit frame for the clamp
  localparam logic [31:0] SHOWN_MAX = 32'h0000_ffff;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_CMP_RD   = 5'b00010,
    S_CMP_CHK  = 5'b00100,
    S_EMIT_RD  = 5'b01000,
    S_EMIT_WR  = 5'b10000
  } state_e;

  // one result word
  typedef struct packed {
    logic [COUNT_W-1:0] run_count;
    logic [BYTE_W-1:0]  word_char;
    logic               last_char;
  } out_word_t;

  // sequencer status toward the top level
  typedef struct packed {
    logic idle;
    logic emitting;
  } seq_status_t;

endpackage

// File: rtl/core/wrc_stream_if.sv
// stream channel interfaces for input bytes and result words
`timescale 1ns / 1ps

interface wrc_in_if;
  logic                       valid;
  logic                       ready;
  logic [wrc_pkg::BYTE_W-1:0] in_byte;
  logic                       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface wrc_out_if;
  logic                        valid;
  logic                        ready;
  logic [wrc_pkg::COUNT_W-1:0] run_count;
  logic [wrc_pkg::BYTE_W-1:0]  word_char;
  logic                        last_char;

  modport source (output valid, output run_count, output word_char, output last_char,
                  input ready);
  modport sink   (input valid, input run_count, input word_char, input last_char,
                  output ready);
endinterface

// File: rtl/core/wrc_word_store.sv
// two-bank character store: one write port, two registered read ports
`timescale 1ns / 1ps

module wrc_word_store #(
  parameter int unsigned AW = 6
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [wrc_pkg::BYTE_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_a_i,
  input  logic [AW-1:0]              raddr_b_i,
  output logic [wrc_pkg::BYTE_W-1:0] rdata_a_o,
  output logic [wrc_pkg::BYTE_W-1:0] rdata_b_o
);

  logic [wrc_pkg::BYTE_W-1:0] mem_q [2**AW];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// File: rtl/core/wrc_seq.sv
// sequencer: collects words, compares them char by char, emits finished runs
`timescale 1ns / 1ps

module wrc_seq #(
  parameter int unsigned MAX_WORD   = 30,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned IDX_W      = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1,
  parameter int unsigned LEN_W      = $clog2(MAX_WORD + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  wrc_in_if.sink                      in_i,
  // character store
  output logic                        mem_we_o,
  output logic [IDX_W:0]              mem_waddr_o,
  output logic [wrc_pkg::BYTE_W-1:0]  mem_wdata_o,
  output logic                        mem_re_o,
  output logic [IDX_W:0]              mem_raddr_a_o,
  output logic [IDX_W:0]              mem_raddr_b_o,
  input  logic [wrc_pkg::BYTE_W-1:0]  mem_rdata_a_i,
  input  logic [wrc_pkg::BYTE_W-1:0]  mem_rdata_b_i,
  // result words
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output wrc_pkg::out_word_t          res_o,
  output wrc_pkg::seq_status_t        status_o
);

  wrc_pkg::state_e      state_q, state_d;
  logic                 cur_bank_q, cur_bank_d;
  logic [LEN_W-1:0]     cur_len_q, cur_len_d;
  logic [LEN_W-1:0]     prev_len_q, prev_len_d;
  logic [COUNT_BITS-1:0] tally_q, tally_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 flush_q, flush_d;

  logic                 idx_last_cur;
  logic                 idx_last_prev;
  logic                 chars_equal;
  logic [31:0]          tally_ext;

  // index compares against both word lengths, and character compare
  assign idx_last_cur  = (LEN_W'(idx_q) + LEN_W'(1)) == cur_len_q;
  assign idx_last_prev = (LEN_W'(idx_q) + LEN_W'(1)) == prev_len_q;
  assign chars_equal   = mem_rdata_a_i == mem_rdata_b_i;

  // store addressing: bank bit on top, current word in cur_bank
  assign mem_waddr_o   = {cur_bank_q, cur_len_q[IDX_W-1:0]};
  assign mem_wdata_o   = in_i.in_byte;
  assign mem_raddr_a_o = {cur_bank_q, idx_q};
  assign mem_raddr_b_o = {~cur_bank_q, idx_q};

  // clamp of the tally for the output field
  assign tally_ext = 32'(tally_q);

  always_comb begin
    res_o.run_count = (tally_ext > wrc_pkg::SHOWN_MAX) ? wrc_pkg::COUNT_W'(wrc_pkg::SHOWN_MAX)
                                                       : tally_ext[wrc_pkg::COUNT_W-1:0];
    res_o.word_char = mem_rdata_b_i;
    res_o.last_char = idx_last_prev;
  end

  assign in_i.ready        = (state_q == wrc_pkg::S_IDLE);
  assign status_o.idle     = (state_q == wrc_pkg::S_IDLE);
  assign status_o.emitting = (state_q == wrc_pkg::S_EMIT_RD) || (state_q == wrc_pkg::S_EMIT_WR);

  // next-state logic
  always_comb begin
    state_d     = state_q;
    cur_bank_d  = cur_bank_q;
    cur_len_d   = cur_len_q;
    prev_len_d  = prev_len_q;
    tally_d     = tally_q;
    idx_d       = idx_q;
    flush_d     = flush_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      wrc_pkg::S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.end_of_input) begin
            if (tally_q != '0) begin
              flush_d = 1'b1;
              idx_d   = '0;
              state_d = wrc_pkg::S_EMIT_RD;
            end else begin
              prev_len_d = '0;
              cur_len_d  = '0;
            end
          end else if (in_i.in_byte != wrc_pkg::NEWLINE) begin
            // append, dropping chars past the word limit
            if (cur_len_q < LEN_W'(MAX_WORD)) begin
              mem_we_o  = 1'b1;
              cur_len_d = cur_len_q + LEN_W'(1);
            end
          end else if (cur_len_q != '0) begin
            if ((tally_q != '0) && (cur_len_q == prev_len_q)) begin
              idx_d   = '0;
              state_d = wrc_pkg::S_CMP_RD;
            end else if (tally_q != '0) begin
              flush_d = 1'b0;
              idx_d   = '0;
              state_d = wrc_pkg::S_EMIT_RD;
            end else begin
              // first run: current word becomes previous
              cur_bank_d = ~cur_bank_q;
              prev_len_d = cur_len_q;
              tally_d    = COUNT_BITS'(1);
              cur_len_d  = '0;
            end
          end
        end
      end

      wrc_pkg::S_CMP_RD: begin
        mem_re_o = 1'b1;
        state_d  = wrc_pkg::S_CMP_CHK;
      end

      wrc_pkg::S_CMP_CHK: begin
        if (!chars_equal) begin
          flush_d = 1'b0;
          idx_d   = '0;
          state_d = wrc_pkg::S_EMIT_RD;
        end else if (idx_last_cur) begin
          // same word: grow the run, saturating
          if (tally_q != '1) begin
            tally_d = tally_q + COUNT_BITS'(1);
          end
          cur_len_d = '0;
          state_d   = wrc_pkg::S_IDLE;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = wrc_pkg::S_CMP_RD;
        end
      end

      wrc_pkg::S_EMIT_RD: begin
        mem_re_o = 1'b1;
        state_d  = wrc_pkg::S_EMIT_WR;
      end

      wrc_pkg::S_EMIT_WR: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (idx_last_prev) begin
            if (flush_q) begin
              tally_d    = '0;
              prev_len_d = '0;
              cur_len_d  = '0;
            end else begin
              // new word starts a fresh run
              cur_bank_d = ~cur_bank_q;
              prev_len_d = cur_len_q;
              tally_d    = COUNT_BITS'(1);
              cur_len_d  = '0;
            end
            state_d = wrc_pkg::S_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = wrc_pkg::S_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = wrc_pkg::S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wrc_pkg::S_IDLE;
      cur_bank_q <= 1'b0;
      cur_len_q  <= '0;
      prev_len_q <= '0;
      tally_q    <= '0;
      idx_q      <= '0;
      flush_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_bank_q <= cur_bank_d;
      cur_len_q  <= cur_len_d;
      prev_len_q <= prev_len_d;
      tally_q    <= tally_d;
      idx_q      <= idx_d;
      flush_q    <= flush_d;
    end
  end

endmodule

// File: rtl/core/word_run_counter.sv
// top level of the word run counter: sequencer, character store, output register
//
//   channel  direction  payload                               handshake
//   in_i     sink       in_byte[7:0], end_of_input            valid / ready
//   out_o    source     run_count[15:0], word_char[7:0],      valid / ready
//                       last_char
//
// a plain byte is taken every cycle while collecting; a newline that matches
// the open run's length enters the compare loop (store read, then check, for
// each character); emitting goes store read, then hand-off, per character.
// the block takes no input while comparing or emitting; a full output
// register stalls the emit loop. reset empties the run and the output
// register; the stored characters need no clearing.
`timescale 1ns / 1ps

module word_run_counter #(
  parameter int unsigned MAX_WORD   = 30,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wrc_in_if.sink    in_i,
  wrc_out_if.source out_o
);

  localparam int unsigned IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_WORD + 1);

  logic                       mem_we;
  logic [IDX_W:0]             mem_waddr;
  logic [wrc_pkg::BYTE_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [IDX_W:0]             mem_raddr_a;
  logic [IDX_W:0]             mem_raddr_b;
  logic [wrc_pkg::BYTE_W-1:0] mem_rdata_a;
  logic [wrc_pkg::BYTE_W-1:0] mem_rdata_b;

  logic                       seq_valid;
  logic                       seq_ready;
  wrc_pkg::out_word_t         seq_word;
  wrc_pkg::seq_status_t       seq_stat;

  logic                       full_q, full_d;
  wrc_pkg::out_word_t         word_q;

  wrc_seq #(
    .MAX_WORD   (MAX_WORD),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W),
    .LEN_W      (LEN_W)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b),
    .res_valid_o   (seq_valid),
    .res_ready_i   (seq_ready),
    .res_o         (seq_word),
    .status_o      (seq_stat)
  );

  wrc_word_store #(
    .AW (IDX_W + 1)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  // output register between the emit loop and the sink
  assign seq_ready = !full_q || out_o.ready;

  always_comb begin
    full_d = full_q;
    if (seq_valid && seq_ready) begin
      full_d = 1'b1;
    end else if (out_o.ready) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_valid && seq_ready) begin
      word_q <= seq_word;
    end
  end

  assign out_o.valid     = full_q;
  assign out_o.run_count = word_q.run_count;
  assign out_o.word_char = word_q.word_char;
  assign out_o.last_char = word_q.last_char;

  // checks
  a_no_input_while_emitting: assert property (
    @(posedge clk_i) disable iff (!rst_ni) seq_stat.emitting |-> !in_i.ready
  ) else $error("input accepted during run emission");

  a_handoff_lands: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (seq_valid && seq_ready) |=> out_o.valid
  ) else $error("handed-off word missing from output register");

  a_count_nonzero: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_o.valid |-> (out_o.run_count != '0)
  ) else $error("result word with zero run count");

  a_idle_no_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni) seq_stat.idle |-> !seq_valid
  ) else $error("result offered while sequencer idle");

endmodule

// File: tb/sv/word_run_counter_test.sv
// self-checking testbench of the word run counter with its own line-run predictor
`timescale 1ns / 1ps

module word_run_counter_test;

  localparam int unsigned MAX_WORD     = 30;
  localparam int unsigned IDLE_PCT     = 30;
  // timeout bound for the whole test sequence
  localparam int unsigned LIMIT_CYCLES = 500_000;
  // a full compare loop plus a full emit loop, with margin
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam logic [wrc_pkg::COUNT_W-1:0] TALLY_MAX = '1;

  typedef logic [wrc_pkg::BYTE_W-1:0] chars_t [$];

  logic clk;
  logic rst_n;

  wrc_in_if  in_ch ();
  wrc_out_if out_ch ();

  word_run_counter #(
    .MAX_WORD  (MAX_WORD),
    .COUNT_BITS(wrc_pkg::COUNT_W)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // predictor state: line being collected, line of the open run, run tally
  logic [wrc_pkg::BYTE_W-1:0]  line_buf [MAX_WORD];
  int unsigned                 line_len;
  logic [wrc_pkg::BYTE_W-1:0]  run_line [MAX_WORD];
  int unsigned                 run_len;
  logic [wrc_pkg::COUNT_W-1:0] run_tally;
  wrc_pkg::out_word_t          run_chars_q [$];

  bit          stall_en;
  int unsigned error_cnt;
  int unsigned bytes_sent;
  int unsigned cycle_cnt;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // predict the result words caused by one accepted input byte
  task automatic predict_byte(input logic [wrc_pkg::BYTE_W-1:0] b, input logic eoi);
    bit                 ends_line;
    bit                 same;
    bit                 closes;
    wrc_pkg::out_word_t w;
    ends_line = !eoi && (b == wrc_pkg::NEWLINE) && (line_len != 0);
    same = ends_line && (run_tally != 0) && (line_len == run_len);
    if (same) begin
      for (int k = 0; k < line_len; k++) begin
        if (line_buf[k] != run_line[k]) same = 1'b0;
      end
    end
    closes = eoi || (ends_line && !same);
    // the open run goes out before the state moves on
    if (closes && run_tally != 0) begin
      for (int k = 0; k < run_len; k++) begin
        w.run_count = run_tally;
        w.word_char = run_line[k];
        w.last_char = (k == run_len - 1);
        run_chars_q.push_back(w);
      end
    end
    if (eoi) begin
      run_tally = '0;
      run_len   = 0;
      line_len  = 0;
    end else if (b != wrc_pkg::NEWLINE) begin
      if (line_len < MAX_WORD) begin
        line_buf[line_len] = b;
        line_len++;
      end
    end else if (ends_line) begin
      if (same) begin
        if (run_tally != TALLY_MAX) run_tally++;
      end else begin
        for (int k = 0; k < line_len; k++) run_line[k] = line_buf[k];
        run_len   = line_len;
        run_tally = 1;
      end
      line_len = 0;
    end
  endtask

  // offer one input byte, with a random gap ahead of it while stalling is enabled, and predict on acceptance
  task automatic send_byte(input logic [wrc_pkg::BYTE_W-1:0] b, input logic eoi);
    if (stall_en && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= b;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_byte(b, eoi);
    bytes_sent++;
  endtask

  task automatic send_line(input chars_t w);
    foreach (w[i]) send_byte(w[i], 1'b0);
    send_byte(wrc_pkg::NEWLINE, 1'b0);
  endtask

  // end of input with a random ignored byte
  task automatic send_end();
    send_byte(wrc_pkg::BYTE_W'($urandom_range(255)), 1'b1);
  endtask

  // sender goes quiet until every predicted word has come back
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (run_chars_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [wrc_pkg::BYTE_W-1:0] next_char(
    input logic [wrc_pkg::BYTE_W-1:0] c);
    logic [wrc_pkg::BYTE_W-1:0] n;
    n = c + 1'b1;
    if (n == wrc_pkg::NEWLINE) n = n + 1'b1;
    return n;
  endfunction

  function automatic chars_t rand_line(input int unsigned len);
    chars_t                     w;
    logic [wrc_pkg::BYTE_W-1:0] b;
    repeat (len) begin
      b = wrc_pkg::BYTE_W'($urandom_range(255));
      while (b == wrc_pkg::NEWLINE) b = wrc_pkg::BYTE_W'($urandom_range(255));
      w.push_back(b);
    end
    return w;
  endfunction

  // end of input and empty lines with no open run give nothing
  task automatic test_no_run();
    send_end();
    send_byte(wrc_pkg::NEWLINE, 1'b0);
    send_byte(wrc_pkg::NEWLINE, 1'b0);
    send_end();
  endtask

  // repeats, a near miss, a prefix and a longer line
  task automatic test_basic_runs();
    chars_t w;
    chars_t v;
    w = rand_line(3);
    send_line(w);
    send_line(w);
    send_line(w);
    v = w;
    v[2] = next_char(v[2]);
    send_line(v);
    v.pop_back();
    send_line(v);
    v.push_back(w[2]);
    v.push_back(w[0]);
    send_line(v);
    send_end();
  endtask

  // byte extremes, end of input carrying a newline or all ones
  task automatic test_char_extremes();
    chars_t w;
    w.push_back(8'h00);
    w.push_back(8'hff);
    w.push_back(8'h09);
    w.push_back(8'h0b);
    w.push_back(8'h7f);
    w.push_back(8'h80);
    send_line(w);
    send_line(w);
    send_byte(wrc_pkg::NEWLINE, 1'b1);
    send_line(w);
    send_byte(8'hff, 1'b1);
  endtask

  // characters past the limit are dropped and do not break equality
  task automatic test_long_lines();
    chars_t w;
    chars_t v;
    w = rand_line(MAX_WORD + 1);
    send_line(w);
    v = w;
    v[MAX_WORD] = next_char(v[MAX_WORD]);
    send_line(v);
    w = rand_line(1);
    send_line(w);
    send_end();
  endtask

  // empty line inside a run, partial line dropped at end of input
  task automatic test_empty_and_partial();
    chars_t w;
    w = rand_line(2);
    send_line(w);
    send_byte(wrc_pkg::NEWLINE, 1'b0);
    send_line(w);
    send_byte(8'h78, 1'b0);
    send_byte(8'h79, 1'b0);
    send_end();
    w = rand_line(4);
    send_line(w);
    send_end();
  endtask

  // runs with no idling on either side
  task automatic test_no_idle();
    chars_t w;
    chars_t v;
    stall_en = 1'b0;
    w = rand_line(4);
    repeat (3) send_line(w);
    v = w;
    v[0] = next_char(v[0]);
    send_line(v);
    send_line(w);
    send_end();
    wait_drain();
    stall_en = 1'b1;
  endtask

  // mostly well-formed lines with repeats and near misses, some noise
  task automatic test_random_lines(input int unsigned target);
    chars_t      last;
    chars_t      w;
    int unsigned start;
    int unsigned pick;
    bit          paused;
    last   = rand_line(3);
    start  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - start < target) begin
      if (!paused && bytes_sent - start >= target / 2) begin
        wait_drain();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      w = last;
      if (pick < 35) begin
        // repeat of the previous line
      end else if (pick < 50) begin
        w[$urandom_range(w.size() - 1)] = next_char(w[$urandom_range(w.size() - 1)]);
      end else if (pick < 60) begin
        if (w.size() > 1) w.pop_back();
        else w.push_back(next_char(w[0]));
      end else if (pick < 80) begin
        if ($urandom_range(99) < 85) w = rand_line($urandom_range(1, 8));
        else w = rand_line($urandom_range(9, 34));
      end else if (pick < 90) begin
        send_byte(wrc_pkg::BYTE_W'($urandom_range(255)), 1'b0);
        continue;
      end else if (pick < 95) begin
        repeat ($urandom_range(3)) begin
          send_byte(next_char(wrc_pkg::BYTE_W'($urandom_range(255))), 1'b0);
        end
        send_end();
        continue;
      end else begin
        send_end();
        continue;
      end
      send_line(w);
      last = w;
    end
    send_end();
  endtask

  // result checker and random output stall
  initial begin
    wrc_pkg::out_word_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (run_chars_q.size() == 0) begin
          $error("result word with no expectation: run_count %0d word_char %0h last_char %0b",
                 out_ch.run_count, out_ch.word_char, out_ch.last_char);
          error_cnt++;
        end else begin
          want = run_chars_q.pop_front();
          if (out_ch.run_count !== want.run_count) begin
            $error("run_count: expected %0d, got %0d", want.run_count, out_ch.run_count);
            error_cnt++;
          end
          if (out_ch.word_char !== want.word_char) begin
            $error("word_char: expected %0h, got %0h", want.word_char, out_ch.word_char);
            error_cnt++;
          end
          if (out_ch.last_char !== want.last_char) begin
            $error("last_char: expected %0b, got %0b", want.last_char, out_ch.last_char);
            error_cnt++;
          end
        end
      end
      out_ch.ready <= !stall_en || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // timeout
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  // test sequence
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = '0;
    in_ch.end_of_input = 1'b0;
    stall_en           = 1'b1;
    line_len           = 0;
    run_len            = 0;
    run_tally          = '0;
    error_cnt          = 0;
    bytes_sent         = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_run();
    test_basic_runs();
    test_char_extremes();
    test_long_lines();
    test_empty_and_partial();
    test_no_idle();
    test_random_lines(30);

    wait_drain();
    if (error_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/wrc_pkg.sv
rtl/core/wrc_stream_if.sv
rtl/core/wrc_word_store.sv
rtl/core/wrc_seq.sv
rtl/core/word_run_counter.sv
tb/sv/word_run_counter_test.sv
